### design/knn_pkg.sv
// Shared types, codes and sizes for the k-nearest-neighbour search block.
// No dependencies; imported by the top level, the controller and the datapath.
package knn_pkg;
   localparam int MAX_SAMPLES  = 1024;
   localparam int MAX_FEATURES = 32;
   localparam int MAX_K        = 16;
   localparam int SIDX_W = $clog2(MAX_SAMPLES);
   localparam int FIDX_W = $clog2(MAX_FEATURES);
   localparam int SLOT_W = $clog2(MAX_K);

   localparam logic [1:0] CMD_WRITE_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_WRITE_QUERY  = 2'd1;
   localparam logic [1:0] CMD_SEARCH       = 2'd2;
   localparam logic [1:0] CMD_UNUSED       = 2'd3;

   localparam logic [1:0] CSR_K_COUNT       = 2'd0;
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_COUNT  = 2'd2;
   localparam logic [1:0] CSR_METRIC        = 2'd3;

   localparam logic METRIC_L2 = 1'b0;
   localparam logic METRIC_L1 = 1'b1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         sample_index;
      logic [4:0]         feature_index;
      logic signed [15:0] element_value;
   } req_type;

   typedef struct packed {
      logic [9:0] neighbour_index;
      logic       found;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [SIDX_W-1:0] sample;
   } tag_type;

   typedef struct packed {
      logic              clear;
      logic              sample_we;
      logic              query_we;
      logic              issue;
      logic              first;
      logic              last;
      logic [SIDX_W-1:0] sample;
      logic [FIDX_W-1:0] feature;
      logic              metric;
      logic [4:0]        k;
      logic [SLOT_W-1:0] out_slot;
   } dp_cmd_type;

   typedef struct packed {
      logic       busy;
      logic [4:0] count;
   } dp_status_type;
endpackage

### design/knn_top_k_search.sv
// Top level of the brute-force k-nearest-neighbour search block.
// Depends on knn_pkg, knn_controller, knn_datapath and knn_ram.
//
// Usage:
//  - req channel: cmd 0 writes one stored element, cmd 1 one query element;
//    each write is a single-cycle transfer. cmd 3 is dropped.
//  - cmd 2 starts a search. The sequencer reads one element per cycle
//    for samples * features elements, then waits for the pipeline
//    (RAM read, difference, square, accumulate, insert) to drain.
//  - Results then leave on rsp, one per cycle when rsp_ready is high:
//    min(k, samples) transfers, farthest first, last set on the final one.
//    An empty store gives one transfer with found low and last high.
//  - req_ready is low from the search transfer until the last result
//    transfer; a stalled receiver just holds the current result.
//  - csr channel is always ready; write only while the block is idle.
//  - Reset (synchronous) returns the sequencer to idle and the registers
//    to k 1, features 1, samples 0, squared euclidean. The vector stores
//    are not cleared and hold garbage until written.
module knn_top_k_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  knn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output knn_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [10:0]      csr_data
);
   import knn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_type       slot_rsp;
   logic          rsp_empty;

   assign csr_ready = 1'b1;

   knn_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_empty(rsp_empty),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .status(status));

   knn_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd),
      .status(status), .slot_rsp(slot_rsp));

   // empty store: not found, index zero, single final transfer
   assign rsp_data = rsp_empty ? '{10'd0, 1'b0, 1'b1} : slot_rsp;

`ifndef SYNTHESIS
   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req accepted during result walk");
   a_not_found_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> rsp_data.last)
      else $error("not-found result without last");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= 5'(MAX_K)) else $error("best list overflow");
`endif
endmodule

### design/knn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### design/knn_datapath.sv
// Datapath: vector stores, distance pipeline, sorted best list.
// Depends on knn_pkg and knn_ram.
module knn_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  knn_pkg::req_type       req,
   input  knn_pkg::dp_cmd_type    cmd,
   output knn_pkg::dp_status_type status,
   output knn_pkg::rsp_type       slot_rsp
);
   import knn_pkg::*;

   logic [15:0] emb_rd, qry_rd;
   tag_type t1_ff, t2_ff, t3_ff, t4_ff;
   logic [15:0] mag_ff, mag_in;
   logic [31:0] term_ff, acc_ff, acc_in;
   logic signed [16:0] diff;
   logic [32:0] sum;
   logic [31:0] dist_ff [MAX_K];
   logic [31:0] dist_in [MAX_K];
   logic [SIDX_W-1:0] idx_ff [MAX_K];
   logic [SIDX_W-1:0] idx_in [MAX_K];
   logic [4:0] cnt_ff, cnt_in;
   logic [MAX_K-1:0] gt;
   logic full, do_ins;

   knn_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES*MAX_FEATURES)) u_emb (
      .clock(clock), .wr_en(cmd.sample_we),
      .wr_addr({req.sample_index, req.feature_index}),
      .wr_data(req.element_value),
      .rd_addr({cmd.sample, cmd.feature}), .rd_data(emb_rd));

   knn_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_qry (
      .clock(clock), .wr_en(cmd.query_we),
      .wr_addr(req.feature_index), .wr_data(req.element_value),
      .rd_addr(cmd.feature), .rd_data(qry_rd));

   // magnitude of difference fits 16 bits unsigned
   always_comb begin
      diff   = $signed({qry_rd[15], qry_rd}) - $signed({emb_rd[15], emb_rd});
      mag_in = diff[16] ? 16'(-diff) : diff[15:0];
      sum    = {1'b0, acc_ff} + {1'b0, term_ff};
      if (t3_ff.first) acc_in = term_ff;
      else             acc_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
         t2_ff.valid <= 1'b0;
         t3_ff.valid <= 1'b0;
         t4_ff.valid <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         t1_ff <= '{cmd.issue, cmd.first, cmd.last, cmd.sample};
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         cnt_ff <= cnt_in;
      end
      mag_ff  <= mag_in;
      term_ff <= (cmd.metric == METRIC_L1) ? {16'd0, mag_ff} :
                 {16'd0, mag_ff} * {16'd0, mag_ff};
      if (t3_ff.valid) acc_ff <= acc_in;
      for (int i = 0; i < MAX_K; i++) begin
         dist_ff[i] <= dist_in[i];
         idx_ff[i]  <= idx_in[i];
      end
   end

   // list kept descending by rank; slot 0 is the farthest
   always_comb begin
      for (int i = 0; i < MAX_K; i++)
         gt[i] = (5'(i) < cnt_ff) && (dist_ff[i] > acc_ff);
      full   = (cnt_ff == cmd.k);
      do_ins = t4_ff.valid && t4_ff.last && (!full || gt[0]);
      cnt_in = cmd.clear ? 5'd0 : ((do_ins && !full) ? cnt_ff + 5'd1 : cnt_ff);
      for (int i = 0; i < MAX_K; i++) begin
         dist_in[i] = dist_ff[i];
         idx_in[i]  = idx_ff[i];
         if (do_ins) begin
            if (!full) begin
               if (!gt[i]) begin
                  if (i == 0 || gt[(i == 0) ? 0 : i-1]) begin
                     dist_in[i] = acc_ff;
                     idx_in[i]  = t4_ff.sample;
                  end else begin
                     dist_in[i] = dist_ff[(i == 0) ? 0 : i-1];
                     idx_in[i]  = idx_ff[(i == 0) ? 0 : i-1];
                  end
               end
            end else begin
               if (i < MAX_K-1 && gt[(i < MAX_K-1) ? i+1 : i]) begin
                  dist_in[i] = dist_ff[(i < MAX_K-1) ? i+1 : i];
                  idx_in[i]  = idx_ff[(i < MAX_K-1) ? i+1 : i];
               end else if (gt[i]) begin
                  dist_in[i] = acc_ff;
                  idx_in[i]  = t4_ff.sample;
               end
            end
         end
      end
   end

   assign status.busy  = t1_ff.valid | t2_ff.valid | t3_ff.valid | t4_ff.valid;
   assign status.count = cnt_ff;
   assign slot_rsp.neighbour_index = idx_ff[cmd.out_slot];
   assign slot_rsp.found = 1'b1;
   assign slot_rsp.last  = ({1'b0, cmd.out_slot} == cnt_ff - 5'd1);
endmodule

### design/knn_controller.sv
// Controller: configuration registers, search sequencer and result walk.
// Depends on knn_pkg.
module knn_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  knn_pkg::req_type       req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_empty,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [10:0]            csr_data,
   output knn_pkg::dp_cmd_type    cmd,
   input  knn_pkg::dp_status_type status
);
   import knn_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RUN   = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_OUT   = 3'd3;
   localparam logic [2:0] S_EMPTY = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [4:0] k_ff;
   logic [5:0] nf_ff;
   logic [10:0] ns_ff;
   logic metric_ff;
   logic [4:0] k_use;
   logic [5:0] nf_use;
   logic [10:0] ns_use;
   logic [10:0] s_ff, s_in;
   logic [5:0] f_ff, f_in;
   logic [SLOT_W-1:0] r_ff, r_in;
   logic acc_req, f_last;

   always_comb begin
      k_use  = (k_ff == 5'd0) ? 5'd1 : ((k_ff > 5'(MAX_K)) ? 5'(MAX_K) : k_ff);
      nf_use = (nf_ff == 6'd0) ? 6'd1 :
               ((nf_ff > 6'(MAX_FEATURES)) ? 6'(MAX_FEATURES) : nf_ff);
      ns_use = (ns_ff > 11'(MAX_SAMPLES)) ? 11'(MAX_SAMPLES) : ns_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign acc_req   = req_valid && req_ready;
   assign f_last    = (f_ff == nf_use - 6'd1);
   assign rsp_valid = (state_ff == S_OUT) || (state_ff == S_EMPTY);
   assign rsp_empty = (state_ff == S_EMPTY);

   always_comb begin
      state_in = state_ff;
      s_in = s_ff;
      f_in = f_ff;
      r_in = r_ff;
      cmd = '0;
      cmd.sample_we = acc_req && (req.cmd == CMD_WRITE_SAMPLE);
      cmd.query_we  = acc_req && (req.cmd == CMD_WRITE_QUERY);
      cmd.sample    = s_ff[SIDX_W-1:0];
      cmd.feature   = f_ff[FIDX_W-1:0];
      cmd.metric    = metric_ff;
      cmd.k         = k_use;
      cmd.out_slot  = r_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc_req && req.cmd == CMD_SEARCH) begin
               cmd.clear = 1'b1;
               s_in = '0;
               f_in = '0;
               r_in = '0;
               state_in = (ns_use == 11'd0) ? S_EMPTY : S_RUN;
            end
         end
         S_RUN: begin
            cmd.issue = 1'b1;
            cmd.first = (f_ff == 6'd0);
            cmd.last  = f_last;
            if (f_last) begin
               f_in = '0;
               s_in = s_ff + 11'd1;
               if (s_ff == ns_use - 11'd1) state_in = S_DRAIN;
            end else begin
               f_in = f_ff + 6'd1;
            end
         end
         S_DRAIN: begin
            if (!status.busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if ({1'b0, r_ff} == status.count - 5'd1) state_in = S_IDLE;
               else r_in = r_ff + SLOT_W'(1);
            end
         end
         S_EMPTY: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         k_ff      <= 5'd1;
         nf_ff     <= 6'd1;
         ns_ff     <= 11'd0;
         metric_ff <= METRIC_L2;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_K_COUNT:       k_ff      <= csr_data[4:0];
               CSR_FEATURE_COUNT: nf_ff     <= csr_data[5:0];
               CSR_SAMPLE_COUNT:  ns_ff     <= csr_data;
               CSR_METRIC:        metric_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
      s_ff <= s_in;
      f_ff <= f_in;
      r_ff <= r_in;
   end
endmodule
